// ===== hw/rtl/dipole_field_evaluator_defines.svh =====
// ----------------------------------------------------------------------------
// Dipole field evaluator assertion macros
// Shared concurrent check macros; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef DIPOLE_FIELD_EVALUATOR_DEFINES_SVH
`define DIPOLE_FIELD_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define DFE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dipole field evaluator: same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define DFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dipole field evaluator: next-cycle check failed");
`else
`define DFE_ASSERT_NOW(lbl, ante, cons)
`define DFE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/dfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Dipole field evaluator package
// Register indexes, status codes, shared types and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_MOMENT_X,
		CFG_MOMENT_Y,
		CFG_MOMENT_Z
	} cfg_reg_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK,
		STAT_SAT,
		STAT_ORIGIN
	} status_t;

	// per-item control carried down the pipe
	typedef struct packed {
		logic       zero;   // point at origin
		logic [4:0] h;      // half of the normalizing shift
	} side_t;

	// reciprocal square root constants, Q2.30
	localparam logic [32:0] RSQ_ONE   = 33'h0_4000_0000;
	localparam logic [32:0] RSQ_TWO   = 33'h0_8000_0000;
	localparam logic [31:0] RSQ_THREE = 32'hC000_0000;
	localparam logic [31:0] RSQ_SEED  = 32'h8000_0000;

	// internal clamps
	localparam logic signed [36:0] D_LIM = 37'sh1_FFFF_FFFF;
	localparam logic signed [37:0] V_LIM = 38'sh3_FFFF_FFFF;

	// output limits
	localparam logic [31:0] OUT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] OUT_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== hw/rtl/dfe_nr_step.sv =====
// ----------------------------------------------------------------------------
// Newton reciprocal square root step
// One iteration y' = y (3 - a y^2) / 2 in Q2.30, over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_nr_step (
	input  logic        clk,
	input  logic [2:0]  en,
	input  logic [31:0] a_in,
	input  logic [31:0] y_in,
	output logic [31:0] a_out,
	output logic [31:0] y_out
);
	import dfe_pkg::*;

	logic [31:0] a_s1, y_s1, a_s2, y_s2, a_s3, y_s3;
	logic [32:0] y2_s1;
	logic [31:0] ay2_s2;
	logic [63:0] sq_c;
	logic [64:0] ay2_c;
	logic [31:0] corr_c;
	logic [63:0] upd_c;
	logic [32:0] yn_c;

	// stage 1: y^2 in Q2.30
	assign sq_c = 64'(y_in) * 64'(y_in);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1  <= a_in;
			y_s1  <= y_in;
			y2_s1 <= sq_c[62:30];
		end
	end

	// stage 2: a * y^2
	assign ay2_c = 65'(a_s1) * 65'(y2_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s2   <= a_s1;
			y_s2   <= y_s1;
			ay2_s2 <= ay2_c[63:32];
		end
	end

	// stage 3: update and clamp to [1, 2]
	assign corr_c = RSQ_THREE - ay2_s2;
	assign upd_c  = 64'(y_s2) * 64'(corr_c);

	always_comb begin
		if (ay2_s2 >= RSQ_THREE) begin
			yn_c = RSQ_ONE;
		end else if (upd_c[63:31] < RSQ_ONE) begin
			yn_c = RSQ_ONE;
		end else if (upd_c[63:31] > RSQ_TWO) begin
			yn_c = RSQ_TWO;
		end else begin
			yn_c = upd_c[63:31];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			a_s3 <= a_s2;
			y_s3 <= yn_c[31:0];
		end
	end

	assign a_out = a_s3;
	assign y_out = y_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/dipole_field_evaluator.sv =====
// The pipeline has 26 register stages. Throughput: one point per cycle unless the
// output stalls; every stage holds its own valid bit, and
// a stage loads whenever it or any stage after it is empty or the output drains.
// The Newton section has four steps of three stages each.
// Reset clears all valid bits and the moment registers to zero; no clearing pass.
// ----------------------------------------------------------------------------
// Dipole field evaluator
// Point dipole field B = (3 (m.u) u - m) / |r|^3 in signed fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dipole_field_evaluator_defines.svh"

module dipole_field_evaluator #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// point channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	// field channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] field_x,
	output logic signed [31:0] field_y,
	output logic signed [31:0] field_z,
	output logic [1:0]  status
);
	import dfe_pkg::*;

	localparam int NS   = 26;
	localparam int EOFF = 3 * FRAC_BITS - 122;
	localparam int EMAX = EOFF + 93;
	localparam int WW   = 65 + ((EMAX > 0) ? EMAX : 0);

	logic [NS:1] v_q, en;
	logic signed [31:0] moment_q [3];

	// ---------------- flow control ----------------
	// a stage loads when it or some later stage is empty or the output drains
	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en[k] = out_ready | ~(&v_q[NS:k]);
	end

	assign in_ready  = en[1];
	assign out_valid = v_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moment_q[0] <= '0;
			moment_q[1] <= '0;
			moment_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MOMENT_X: moment_q[0] <= cfg_data;
				CFG_MOMENT_Y: moment_q[1] <= cfg_data;
				CFG_MOMENT_Z: moment_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- position and control delay lines ----------------
	logic signed [31:0] pos_sk [1:17][3];
	side_t              side_sk [2:25];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pos_sk[1][0] <= pos_x;
			pos_sk[1][1] <= pos_y;
			pos_sk[1][2] <= pos_z;
		end
		for (int k = 2; k <= 17; k++) begin
			if (en[k]) begin
				pos_sk[k] <= pos_sk[k-1];
			end
		end
	end

	// ---------------- stage 1: squares ----------------
	logic [62:0] sq_s1 [3];
	logic signed [63:0] sq_c [3];

	always_comb begin
		sq_c[0] = 64'(pos_x) * 64'(pos_x);
		sq_c[1] = 64'(pos_y) * 64'(pos_y);
		sq_c[2] = 64'(pos_z) * 64'(pos_z);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= sq_c[i][62:0];
			end
		end
	end

	// ---------------- stage 2: |r|^2 ----------------
	logic [63:0] r2_s2, r2_c;

	assign r2_c = 64'(sq_s1[0]) + 64'(sq_s1[1]) + 64'(sq_s1[2]);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			r2_s2 <= r2_c;
		end
	end

	// ---------------- stages 3-5: even normalize, seed ----------------
	logic [63:0] nrm_s3, nrm_s4, n3_c, n4_c, n5_c;
	logic [4:0]  h3_c, h4_c, h5_c;
	logic [31:0] a_s5, y0_s5;

	always_comb begin
		n3_c = r2_s2;
		h3_c = side_sk[2].h;
		if (n3_c[63:32] == '0) begin
			n3_c = n3_c << 32;
			h3_c = h3_c | 5'd16;
		end
		if (n3_c[63:48] == '0) begin
			n3_c = n3_c << 16;
			h3_c = h3_c | 5'd8;
		end
		n4_c = nrm_s3;
		h4_c = side_sk[3].h;
		if (n4_c[63:56] == '0) begin
			n4_c = n4_c << 8;
			h4_c = h4_c | 5'd4;
		end
		if (n4_c[63:60] == '0) begin
			n4_c = n4_c << 4;
			h4_c = h4_c | 5'd2;
		end
		n5_c = nrm_s4;
		h5_c = side_sk[4].h;
		if (n5_c[63:62] == '0) begin
			n5_c = n5_c << 2;
			h5_c = h5_c | 5'd1;
		end
	end

	// control side band for every stage lives in this one block
	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_sk[2].zero <= (r2_c == '0);
			side_sk[2].h    <= '0;
		end
		if (en[3]) begin
			nrm_s3       <= n3_c;
			side_sk[3].h    <= h3_c;
			side_sk[3].zero <= side_sk[2].zero;
		end
		if (en[4]) begin
			nrm_s4       <= n4_c;
			side_sk[4].h    <= h4_c;
			side_sk[4].zero <= side_sk[3].zero;
		end
		if (en[5]) begin
			a_s5         <= n5_c[63:32];
			y0_s5        <= RSQ_SEED - {2'b00, n5_c[63:34]};
			side_sk[5].h    <= h5_c;
			side_sk[5].zero <= side_sk[4].zero;
		end
		for (int k = 6; k <= 25; k++) begin
			if (en[k]) begin
				side_sk[k] <= side_sk[k-1];
			end
		end
	end

	// ---------------- stages 6-17: Newton iterations ----------------
	logic [31:0] a_nr [5];
	logic [31:0] y_nr [5];

	assign a_nr[0] = a_s5;
	assign y_nr[0] = y0_s5;

	for (genvar j = 0; j < 4; j++) begin : g_nr
		dfe_nr_step u_step (
			.clk   (clk),
			.en    (en[6+3*j +: 3]),
			.a_in  (a_nr[j]),
			.y_in  (y_nr[j]),
			.a_out (a_nr[j+1]),
			.y_out (y_nr[j+1])
		);
	end

	// ---------------- stage 18: p*y, y^2 ----------------
	logic signed [63:0] prod_s18 [3];
	logic [32:0]        yy_s18;
	logic [31:0]        y_s18;
	logic [63:0]        yy_c;

	assign yy_c = 64'(y_nr[4]) * 64'(y_nr[4]);

	always_ff @(posedge clk) begin
		if (en[18]) begin
			for (int i = 0; i < 3; i++) begin
				prod_s18[i] <= 64'(pos_sk[17][i]) * $signed(64'(y_nr[4]));
			end
			yy_s18 <= yy_c[62:30];
			y_s18  <= y_nr[4];
		end
	end

	// ---------------- stage 19: unit vector, y^3 product ----------------
	logic signed [31:0] u_s19 [3];
	logic [63:0]        y3p_s19;
	logic [5:0]         ush_c;
	logic signed [63:0] ushr_c [3];

	always_comb begin
		ush_c = 6'd33 - {1'b0, side_sk[18].h};
		for (int i = 0; i < 3; i++) begin
			ushr_c[i] = prod_s18[i] >>> ush_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[19]) begin
			for (int i = 0; i < 3; i++) begin
				u_s19[i] <= ushr_c[i][31:0];
			end
			y3p_s19 <= 64'(yy_s18) * 64'(y_s18);
		end
	end

	// ---------------- stage 20: m_i * u_i ----------------
	logic signed [63:0] mu_s20 [3];
	logic signed [31:0] u_s20 [3];
	logic [29:0]        y3_s20;

	always_ff @(posedge clk) begin
		if (en[20]) begin
			for (int i = 0; i < 3; i++) begin
				mu_s20[i] <= 64'(moment_q[i]) * 64'(u_s19[i]);
			end
			u_s20  <= u_s19;
			y3_s20 <= y3p_s19[63:34];
		end
	end

	// ---------------- stage 21: D = (m.u) >> 29, clamped ----------------
	logic signed [65:0] sum_c;
	logic signed [36:0] dq_c;
	logic signed [33:0] d_s21;
	logic               sat_s21;
	logic signed [31:0] u_s21 [3];
	logic [29:0]        y3_s21;

	always_comb begin
		sum_c = 66'(mu_s20[0]) + 66'(mu_s20[1]) + 66'(mu_s20[2]);
		dq_c  = sum_c[65:29];
	end

	always_ff @(posedge clk) begin
		if (en[21]) begin
			if (dq_c > D_LIM) begin
				d_s21   <= D_LIM[33:0];
				sat_s21 <= 1'b1;
			end else if (dq_c < -D_LIM) begin
				d_s21   <= 34'(-D_LIM);
				sat_s21 <= 1'b1;
			end else begin
				d_s21   <= dq_c[33:0];
				sat_s21 <= 1'b0;
			end
			u_s21  <= u_s20;
			y3_s21 <= y3_s20;
		end
	end

	// ---------------- stage 22: D * u_i ----------------
	logic signed [63:0] du_s22 [3];
	logic               sat_s22;
	logic [29:0]        y3_s22;

	always_ff @(posedge clk) begin
		if (en[22]) begin
			for (int i = 0; i < 3; i++) begin
				du_s22[i] <= 64'(d_s21) * 64'(u_s21[i]);
			end
			sat_s22 <= sat_s21;
			y3_s22  <= y3_s21;
		end
	end

	// ---------------- stage 23: V_i = 3 pr - m_i, clamped ----------------
	logic signed [34:0] v_s23 [3];
	logic               sat_s23;
	logic [29:0]        y3_s23;
	logic signed [37:0] t3_c [3];
	logic signed [34:0] v_c [3];
	logic [2:0]         vsat_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t3_c[i] = 38'($signed(du_s22[i][63:29])) + 38'($signed(du_s22[i][63:29])) +
				38'($signed(du_s22[i][63:29])) - 38'(moment_q[i]);
			if (t3_c[i] > V_LIM) begin
				v_c[i]    = V_LIM[34:0];
				vsat_c[i] = 1'b1;
			end else if (t3_c[i] < -V_LIM) begin
				v_c[i]    = 35'(-V_LIM);
				vsat_c[i] = 1'b1;
			end else begin
				v_c[i]    = t3_c[i][34:0];
				vsat_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[23]) begin
			v_s23   <= v_c;
			sat_s23 <= sat_s22 | (|vsat_c);
			y3_s23  <= y3_s22;
		end
	end

	// ---------------- stage 24: V_i * y^3 ----------------
	logic signed [63:0] vy_s24 [3];
	logic               sat_s24;

	always_ff @(posedge clk) begin
		if (en[24]) begin
			for (int i = 0; i < 3; i++) begin
				vy_s24[i] <= 64'(v_s23[i]) * $signed(64'(y3_s23));
			end
			sat_s24 <= sat_s23;
		end
	end

	// ---------------- stage 25: scale by 2^e, round to nearest ----------------
	logic signed [WW-1:0] w_s25 [3];
	logic                 sat_s25;
	logic signed [8:0]    e_c;
	logic [8:0]           n_c;
	logic signed [64:0]   rsum_c [3];
	logic signed [WW-1:0] w_c [3];

	always_comb begin
		e_c = $signed(9'(EOFF)) + $signed({3'b000, side_sk[24].h, 1'b0}) +
			$signed({4'b0000, side_sk[24].h});
		n_c = 9'(-e_c);
		for (int i = 0; i < 3; i++) begin
			rsum_c[i] = 65'(vy_s24[i]) + $signed(65'd1 << (n_c[5:0] - 6'd1));
			if (e_c >= 0) begin
				w_c[i] = WW'(vy_s24[i]) <<< e_c[7:0];
			end else if (n_c >= 9'd63) begin
				w_c[i] = '0;
			end else begin
				w_c[i] = WW'(rsum_c[i] >>> n_c[5:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[25]) begin
			w_s25   <= w_c;
			sat_s25 <= sat_s24;
		end
	end

	// ---------------- stage 26: saturate, output register ----------------
	logic signed [31:0] fld_s26 [3];
	status_t            status_s26;
	logic signed [31:0] f_c [3];
	logic [2:0]         osat_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if ((&w_s25[i][WW-1:31]) | ~(|w_s25[i][WW-1:31])) begin
				f_c[i]    = w_s25[i][31:0];
				osat_c[i] = 1'b0;
			end else begin
				f_c[i]    = w_s25[i][WW-1] ? OUT_MIN : OUT_MAX;
				osat_c[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[26]) begin
			if (side_sk[25].zero) begin
				fld_s26[0] <= '0;
				fld_s26[1] <= '0;
				fld_s26[2] <= '0;
				status_s26 <= STAT_ORIGIN;
			end else begin
				fld_s26    <= f_c;
				status_s26 <= (sat_s25 | (|osat_c)) ? STAT_SAT : STAT_OK;
			end
		end
	end

	assign field_x = fld_s26[0];
	assign field_y = fld_s26[1];
	assign field_z = fld_s26[2];
	assign status  = status_s26;

	// ---------------- checks ----------------
	`DFE_ASSERT_NOW(a_origin_zero, out_valid && status == STAT_ORIGIN, field_x == 0 && field_y == 0 && field_z == 0)
	`DFE_ASSERT_NOW(a_bubble_ready, !v_q[NS], in_ready)
	`DFE_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_q[1])

endmodule

`default_nettype wire
